### rtl/cubic_joint_trajectory_pd_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic joint trajectory servo
// Implication and next-cycle forms; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CUBIC_JOINT_TRAJECTORY_PD_MACROS_SVH
`define CUBIC_JOINT_TRAJECTORY_PD_MACROS_SVH

`ifndef SYNTHESIS
`define CJTPD_ASSERT_IMP(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define CJTPD_ASSERT_NXT(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CJTPD_ASSERT_IMP(lbl, clock, rstn, ante, cons, msg)
`define CJTPD_ASSERT_NXT(lbl, clock, rstn, ante, cons, msg)
`endif

`endif

### rtl/cjtpd_pkg.sv
// ----------------------------------------------------------------------------
// cjtpd_pkg
// Types, constants and helpers shared by the cubic joint trajectory servo.
// ----------------------------------------------------------------------------
package cjtpd_pkg;

	localparam int JOINTS = 8;
	localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	localparam int CFG_AW = 3;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// register index taken from paddr[2]
	localparam logic REG_DURATION     = 1'b0;
	localparam logic REG_INV_DURATION = 1'b1;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

	typedef struct packed {
		logic               opcode;
		logic [2:0]         joint;
		logic [30:0]        now_time;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic signed [31:0] gravity_torque;
		logic signed [31:0] goal_position;
		logic [30:0]        prop_gain;
		logic [30:0]        deriv_gain;
	} req_t;

	typedef struct packed {
		logic [2:0]         out_joint;
		logic signed [31:0] torque;
		logic signed [31:0] desired_position;
		logic               segment_done;
	} rsp_t;

	typedef struct packed {
		logic [30:0] duration;
		logic [30:0] inv_duration;
	} cfg_t;

	// one row of the per-joint segment memory
	typedef struct packed {
		logic signed [31:0] start_angle;
		logic signed [31:0] angle_delta;
		logic [30:0]        start_time;
		logic [30:0]        kp;
		logic [30:0]        kv;
	} seg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELAP,
		ST_CHK,
		ST_S,
		ST_S2,
		ST_SHAPE,
		ST_VEL1,
		ST_POS,
		ST_DVEL,
		ST_ERR,
		ST_KP,
		ST_KV,
		ST_FIN
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX)
			r = SAT_MAX[31:0];
		else if (v < SAT_MIN)
			r = SAT_MIN[31:0];
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

### rtl/cjtpd_cfg.sv
// ----------------------------------------------------------------------------
// cjtpd_cfg
// APB register file: trajectory duration and its reciprocal.
// ----------------------------------------------------------------------------
module cjtpd_cfg
	import cjtpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output cfg_t              cfg
);

	logic [30:0] duration_q;
	logic [30:0] inv_duration_q;
	logic        wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q     <= 31'(ONE_Q16);
			inv_duration_q <= 31'(ONE_Q16);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_DURATION:     duration_q     <= pwdata[30:0];
				REG_INV_DURATION: inv_duration_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DURATION:     prdata = {1'b0, duration_q};
			REG_INV_DURATION: prdata = {1'b0, inv_duration_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg.duration     = duration_q;
	assign cfg.inv_duration = inv_duration_q;

endmodule

### rtl/cubic_joint_trajectory_pd.sv
// ----------------------------------------------------------------------------
// cubic_joint_trajectory_pd
// Per-joint cubic trajectory servo with PD torque and gravity feed-through.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------
//  request   | req_valid / req_stall | req  (req_t)
//  result    | rsp_valid / rsp_stall | rsp  (rsp_t)
//  config    | APB psel/penable      | paddr, pwdata, prdata
//
//  A load is written as it is taken. A tick on an inactive or finished joint
//  goes through ELAP, CHK and FIN; a running tick goes through every step of the
//  sequence set by the eight products that share one 33x33 multiplier, each followed by a register.
//  Segment rows live in a one-port synchronous memory, read as the request
//  is taken; active bits are flops cleared by reset.
//  A finished result waits in the output register; a full, stalled output
//  holds the last state until the slot frees.
// ----------------------------------------------------------------------------
`include "cubic_joint_trajectory_pd_macros.svh"

module cubic_joint_trajectory_pd
	import cjtpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg;

	cjtpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	state_t state_q, state_d;

	logic              req_acc;
	logic              jvalid_w;
	logic [JIDX_W-1:0] idx_w;
	seg_t              wr_row;

	seg_t              seg_mem [JOINTS];
	seg_t              rd_q;
	logic [JOINTS-1:0] active_q;
	logic              act_q;
	req_t              item_q;

	logic [30:0]        elapsed_q;
	logic [16:0]        s_q;
	logic [16:0]        s2_q;
	logic signed [19:0] blend_q;
	logic signed [19:0] shape_q;
	logic signed [31:0] v1_q;
	logic signed [31:0] qdes_q;
	logic signed [31:0] dqdes_q;
	logic signed [31:0] perr_q;
	logic signed [31:0] verr_q;
	logic signed [48:0] acc_q;
	logic               done_q;
	logic signed [63:0] prod_q;

	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] prod_w;
	logic signed [47:0] fl16_w;
	logic [16:0]        s_w;
	logic [16:0]        lo17_w;
	logic signed [19:0] s2_x;
	logic signed [19:0] s3_x;
	logic signed [19:0] s_x;
	logic               slot_free;
	logic signed [31:0] torque_w;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign jvalid_w  = (32'(req.joint) < JOINTS);
	assign idx_w     = JIDX_W'(req.joint);

	always_comb begin
		wr_row.start_angle = req.position;
		wr_row.angle_delta = sat32(64'(req.goal_position) - 64'(req.position));
		wr_row.start_time  = req.now_time;
		wr_row.kp          = req.prop_gain;
		wr_row.kv          = req.deriv_gain;
	end

	// segment memory: one item in flight; a load writes its row and reads the old contents in the same cycle
	always_ff @(posedge clk) begin
		if (req_acc && req.opcode == OP_LOAD && jvalid_w)
			seg_mem[idx_w] <= wr_row;
		if (req_acc)
			rd_q <= seg_mem[idx_w];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (req_acc && req.opcode == OP_LOAD && jvalid_w) begin
			active_q[idx_w] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_q <= req;
			act_q  <= jvalid_w && active_q[idx_w];
		end
	end

	// shared multiplier, operands picked by step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_CHK: begin
				mul_a = {2'b00, elapsed_q};
				mul_b = {2'b00, cfg.inv_duration};
			end
			ST_S: begin
				mul_a = {16'd0, s_w};
				mul_b = {16'd0, s_w};
			end
			ST_S2: begin
				mul_a = {16'd0, lo17_w};
				mul_b = {16'd0, s_q};
			end
			ST_VEL1: begin
				mul_a = 33'(rd_q.angle_delta);
				mul_b = 33'(shape_q);
			end
			ST_POS: begin
				mul_a = 33'(rd_q.angle_delta);
				mul_b = 33'(blend_q);
			end
			ST_DVEL: begin
				mul_a = 33'(v1_q);
				mul_b = {2'b00, cfg.inv_duration};
			end
			ST_KP: begin
				mul_a = {2'b00, rd_q.kp};
				mul_b = 33'(perr_q);
			end
			ST_KV: begin
				mul_a = {2'b00, rd_q.kv};
				mul_b = 33'(verr_q);
			end
			default: ;
		endcase
	end

	assign prod_w = mul_a * mul_b;
	assign fl16_w = $signed(prod_q[63:16]);
	// products of values at most 1.0 stay within 17 bits after the shift
	assign lo17_w = prod_q[32:16];
	assign s_w    = (prod_q[63:16] > 48'(ONE_Q16)) ? ONE_Q16 : prod_q[32:16];
	assign s_x    = $signed({3'b000, s_q});
	assign s2_x   = $signed({3'b000, s2_q});
	assign s3_x   = $signed({3'b000, lo17_w});

	always_ff @(posedge clk) begin
		// last product feeds the torque sum, so it holds while the result waits
		if (state_q != ST_FIN)
			prod_q <= prod_w[63:0];
		unique case (state_q)
			ST_ELAP: begin
				elapsed_q <= (item_q.now_time >= rd_q.start_time) ?
					(item_q.now_time - rd_q.start_time) : '0;
			end
			ST_CHK: begin
				if (!act_q) begin
					qdes_q <= '0;
					done_q <= 1'b1;
				end else if (elapsed_q > cfg.duration) begin
					qdes_q <= sat32(64'(rd_q.start_angle) + 64'(rd_q.angle_delta));
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end
			ST_S:     s_q  <= s_w;
			ST_S2:    s2_q <= lo17_w;
			ST_SHAPE: begin
				blend_q <= s2_x + (s2_x <<< 1) - (s3_x <<< 1);
				shape_q <= (s_x <<< 2) + (s_x <<< 1) - (s2_x <<< 2) - (s2_x <<< 1);
			end
			ST_POS:   v1_q <= sat32(64'(fl16_w));
			ST_DVEL:  qdes_q <= sat32(64'(rd_q.start_angle) + 64'(fl16_w));
			ST_ERR: begin
				dqdes_q <= sat32(64'(fl16_w));
				perr_q  <= sat32(64'(qdes_q) - 64'(item_q.position));
			end
			ST_KP:    verr_q <= sat32(64'(dqdes_q) - 64'(item_q.velocity));
			ST_KV:    acc_q  <= 49'(fl16_w) + 49'(item_q.gravity_torque);
			default: ;
		endcase
	end

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign torque_w  = done_q ? item_q.gravity_torque : sat32(64'(acc_q) + 64'(fl16_w));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (req_acc && req.opcode == OP_TICK) state_d = ST_ELAP;
			ST_ELAP:  state_d = ST_CHK;
			ST_CHK:   state_d = (!act_q || elapsed_q > cfg.duration) ? ST_FIN : ST_S;
			ST_S:     state_d = ST_S2;
			ST_S2:    state_d = ST_SHAPE;
			ST_SHAPE: state_d = ST_VEL1;
			ST_VEL1:  state_d = ST_POS;
			ST_POS:   state_d = ST_DVEL;
			ST_DVEL:  state_d = ST_ERR;
			ST_ERR:   state_d = ST_KP;
			ST_KP:    state_d = ST_KV;
			ST_KV:    state_d = ST_FIN;
			ST_FIN:   if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			rsp_q.out_joint        <= item_q.joint;
			rsp_q.torque           <= torque_w;
			rsp_q.desired_position <= qdes_q;
			rsp_q.segment_done     <= done_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`CJTPD_ASSERT_NXT(a_tick_starts, clk, arst_n, req_acc && req.opcode == OP_TICK, state_q == ST_ELAP, "tick request did not start the sequence")
	`CJTPD_ASSERT_NXT(a_load_marks, clk, arst_n, req_acc && req.opcode == OP_LOAD && jvalid_w, active_q[$past(idx_w)], "load did not mark joint active")
	`CJTPD_ASSERT_IMP(a_s_clamped, clk, arst_n, state_q == ST_S2, s_q <= ONE_Q16, "blend parameter above one")
	`CJTPD_ASSERT_NXT(a_fin_holds, clk, arst_n, state_q == ST_FIN && rsp_valid_q && rsp_stall, state_q == ST_FIN && rsp_valid_q, "result dropped while output stalled")

endmodule

### dv/cubic_joint_trajectory_pd_tb.sv
// ----------------------------------------------------------------------------
// cubic_joint_trajectory_pd_tb
// Self-checking bench for the per-joint cubic trajectory servo. A predictor
// works out the torque, desired position and done flag of every accepted tick
// and the results are matched in order. Directed segments cover the edges of
// the trajectory and saturation. Random phases reprogram the duration and its
// reciprocal and mix well-formed load/tick sequences with noise. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module cubic_joint_trajectory_pd_tb;
	import cjtpd_pkg::*;

	localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;
	localparam int ITEMS_TARGET = 550;
	localparam int PHASE_ITEMS = 55;
	localparam int IDLE_GAP = 20;
	localparam int WATCHDOG_LIMIT = 1000;

	class torque_predictor;
		logic [30:0] seg_len = 31'd65536;
		logic [30:0] seg_rate = 31'd65536;
		logic signed [31:0] seg_origin [JOINTS];
		logic signed [31:0] seg_span [JOINTS];
		logic [30:0] seg_t0 [JOINTS];
		logic [30:0] kp_gain [JOINTS];
		logic [30:0] kv_gain [JOINTS];
		bit armed [JOINTS];
		rsp_t pending_torques [$];
		int errors = 0;

		static function longint clamp32(longint v);
			if (v > 64'sh7FFF_FFFF)
				return 64'sh7FFF_FFFF;
			if (v < -64'sh8000_0000)
				return -64'sh8000_0000;
			return v;
		endfunction

		function void note_request(req_t r);
			longint now_l, t0, elapsed, rate, s, s2, s3, blend, shape;
			longint a0, d, q, dq, grav, qdes, v1, dqdes, perr, verr, acc;
			rsp_t e;
			int j;
			j = r.joint;
			if (r.opcode == OP_LOAD) begin
				a0 = $signed(r.position);
				d = $signed(r.goal_position);
				seg_origin[j] = r.position;
				seg_span[j] = 32'(clamp32(d - a0));
				seg_t0[j] = r.now_time;
				kp_gain[j] = r.prop_gain;
				kv_gain[j] = r.deriv_gain;
				armed[j] = 1'b1;
				return;
			end
			grav = $signed(r.gravity_torque);
			e.out_joint = r.joint;
			e.torque = r.gravity_torque;
			e.desired_position = '0;
			e.segment_done = 1'b1;
			if (armed[j]) begin
				now_l = r.now_time;
				t0 = seg_t0[j];
				elapsed = (now_l >= t0) ? now_l - t0 : 0;
				a0 = seg_origin[j];
				d = seg_span[j];
				if (elapsed > longint'(seg_len)) begin
					e.desired_position = 32'(clamp32(a0 + d));
				end else begin
					rate = seg_rate;
					s = (elapsed * rate) >>> 16;
					if (s > 65536)
						s = 65536;
					s2 = (s * s) >>> 16;
					s3 = (s2 * s) >>> 16;
					blend = 3 * s2 - 2 * s3;
					shape = 6 * s - 6 * s2;
					qdes = clamp32(a0 + ((d * blend) >>> 16));
					v1 = clamp32((d * shape) >>> 16);
					dqdes = clamp32((v1 * rate) >>> 16);
					q = $signed(r.position);
					dq = $signed(r.velocity);
					perr = clamp32(qdes - q);
					verr = clamp32(dqdes - dq);
					acc = ((longint'(kp_gain[j]) * perr) >>> 16)
						+ ((longint'(kv_gain[j]) * verr) >>> 16) + grav;
					e.desired_position = 32'(qdes);
					e.torque = 32'(clamp32(acc));
					e.segment_done = 1'b0;
				end
			end
			pending_torques.push_back(e);
		endfunction

		function void mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
			$display("%0t: %s mismatch, expected %0d got %0d", $time, field,
				$signed(exp_v), $signed(got_v));
			errors++;
		endfunction

		function void check_torque(rsp_t got);
			rsp_t e;
			if (pending_torques.size() == 0) begin
				$display("%0t: unexpected result, joint %0d torque %0d", $time,
					got.out_joint, $signed(got.torque));
				errors++;
				return;
			end
			e = pending_torques.pop_front();
			if (got.out_joint !== e.out_joint)
				mismatch("out_joint", 32'(e.out_joint), 32'(got.out_joint));
			if (got.torque !== e.torque)
				mismatch("torque", e.torque, got.torque);
			if (got.desired_position !== e.desired_position)
				mismatch("desired_position", e.desired_position, got.desired_position);
			if (got.segment_done !== e.segment_done)
				mismatch("segment_done", 32'(e.segment_done), 32'(got.segment_done));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	torque_predictor predictor = new();
	logic [30:0] seg_start [JOINTS];
	bit loaded [JOINTS];
	bit steady_sender = 1'b0;
	int sent = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	cubic_joint_trajectory_pd dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check, then pick the stall pattern for the next cycles
	always @(posedge clk) begin
		int roll;
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
			predictor.check_torque(rsp);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				rsp_stall <= 1'b0;
				stall_left <= $urandom_range(0, 30);
			end else if (roll < 90) begin
				rsp_stall <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				rsp_stall <= 1'b1;
				stall_left <= $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid === 1'b1 && req_stall === 1'b0) ||
				(rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic signed [31:0] spread(int bits);
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $signed($urandom) >>> (31 - bits);
	endfunction

	function automatic logic [30:0] rand_gain();
		if ($urandom_range(0, 9) == 0)
			return 31'($urandom);
		return 31'($urandom >> $urandom_range(7, 14));
	endfunction

	function automatic req_t random_fields();
		req_t r;
		r.opcode = 1'($urandom);
		r.joint = 3'($urandom);
		r.now_time = 31'($urandom);
		r.position = $urandom;
		r.velocity = $urandom;
		r.gravity_torque = $urandom;
		r.goal_position = $urandom;
		r.prop_gain = 31'($urandom);
		r.deriv_gain = 31'($urandom);
		return r;
	endfunction

	function automatic req_t load_item(logic [2:0] j, logic [30:0] t0,
			logic signed [31:0] start, logic signed [31:0] goal,
			logic [30:0] kp, logic [30:0] kv);
		req_t r;
		r = random_fields();
		r.opcode = OP_LOAD;
		r.joint = j;
		r.now_time = t0;
		r.position = start;
		r.goal_position = goal;
		r.prop_gain = kp;
		r.deriv_gain = kv;
		return r;
	endfunction

	function automatic req_t tick_item(logic [2:0] j, logic [30:0] now,
			logic signed [31:0] q, logic signed [31:0] dq, logic signed [31:0] grav);
		req_t r;
		r = random_fields();
		r.opcode = OP_TICK;
		r.joint = j;
		r.now_time = now;
		r.position = q;
		r.velocity = dq;
		r.gravity_torque = grav;
		return r;
	endfunction

	// mostly loads and ticks that land inside a loaded segment
	function automatic req_t next_item();
		int roll;
		int j;
		longint dur;
		longint at;
		roll = $urandom_range(0, 99);
		j = $urandom_range(0, JOINTS - 1);
		dur = predictor.seg_len;
		if (roll < 8)
			return random_fields();
		if (roll < 28 || !loaded[j])
			return load_item(3'(j), 31'($urandom_range(0, 32'(longint'(T_MAX) - dur))),
				spread(19), spread(20), rand_gain(), rand_gain());
		roll = $urandom_range(0, 99);
		if (roll < 75)
			at = seg_start[j] + longint'($urandom_range(0, 32'(dur)));
		else if (roll < 87)
			at = seg_start[j] + dur + 1 + $urandom_range(0, 2000);
		else if (roll < 94)
			at = (seg_start[j] == 0) ? 0 : $urandom_range(0, 32'(seg_start[j]) - 1);
		else
			at = $urandom_range(0, 32'(T_MAX));
		if (at > T_MAX)
			at = T_MAX;
		return tick_item(3'(j), 31'(at), spread(19), spread(21), spread(22));
	endfunction

	task automatic send_request(req_t r);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (steady_sender || roll < 45)
			gap = 0;
		else if (roll < 85)
			gap = $urandom_range(1, 3);
		else if (roll < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 40);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		predictor.note_request(r);
		if (r.opcode == OP_LOAD) begin
			seg_start[r.joint] = r.now_time;
			loaded[r.joint] = 1'b1;
		end
		sent++;
	endtask

	// drop valid and wait for every expected result, then linger
	task automatic settle(int extra);
		req_valid <= 1'b0;
		do @(posedge clk); while (predictor.pending_torques.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [30:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_DURATION)
			predictor.seg_len = value;
		else
			predictor.seg_rate = value;
		// return to idle before the next transfer
		@(posedge clk);
	endtask

	initial begin
		logic [30:0] dur;
		logic [30:0] rate;
		longint ratio;
		int roll;
		int phase;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: 1 s segment, unit rate
		send_request(tick_item(3'd0, 31'd0, 32'sd0, 32'sd0, 32'sh7FFF_FFFF));
		send_request(tick_item(3'd7, T_MAX, 32'sd0, 32'sd0, 32'sh8000_0000));
		send_request(load_item(3'd0, 31'd1000, 32'sd0, 32'sd131072, 31'd65536, 31'd32768));
		send_request(tick_item(3'd0, 31'd1000, 32'sd0, 32'sd0, 32'sd0));
		send_request(tick_item(3'd0, 31'd33768, 32'sd4096, -32'sd8192, 32'sd100));
		// elapsed equal to the duration still runs the PD law
		send_request(tick_item(3'd0, 31'd66536, 32'sd0, 32'sd0, 32'sd0));
		send_request(tick_item(3'd0, 31'd66537, 32'sd0, 32'sd0, 32'sd5));
		send_request(tick_item(3'd0, 31'd500, 32'sd0, 32'sd0, 32'sd0));
		// goal minus start overflows; full gains drive the torque into saturation
		send_request(load_item(3'd1, 31'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF,
			31'h7FFF_FFFF));
		send_request(tick_item(3'd1, 31'd40000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF));
		send_request(tick_item(3'd1, 31'd20000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000));
		send_request(tick_item(3'd1, 31'd70000, 32'sd0, 32'sd0, -32'sd1));
		send_request(load_item(3'd7, T_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'd0, 31'd0));
		send_request(tick_item(3'd7, T_MAX, 32'sd0, 32'sd0, 32'sd7));
		send_request(tick_item(3'd7, 31'd0, 32'sd0, 32'sd0, 32'sd7));
		settle(IDLE_GAP);

		// rate far too high: s clamps at 1.0
		write_reg(REG_INV_DURATION, T_MAX);
		send_request(tick_item(3'd0, 31'd31000, 32'sd0, 32'sd100, 32'sd0));
		settle(IDLE_GAP);

		write_reg(REG_DURATION, 31'd1);
		write_reg(REG_INV_DURATION, 31'd1);
		send_request(tick_item(3'd0, 31'd1001, 32'sd0, 32'sd0, 32'sd0));
		send_request(tick_item(3'd0, 31'd1002, 32'sd0, 32'sd0, 32'sd0));
		settle(IDLE_GAP);

		write_reg(REG_DURATION, T_MAX);
		send_request(tick_item(3'd0, T_MAX, 32'sd65536, -32'sd65536, 32'sd3));
		send_request(tick_item(3'd1, T_MAX, 32'sd0, 32'sd0, 32'sd3));
		settle(IDLE_GAP);

		for (phase = 0; sent < ITEMS_TARGET; phase++) begin
			roll = $urandom_range(0, 9);
			if (phase == 0) begin
				dur = 31'd1;
				rate = T_MAX;
			end else if (phase == 1) begin
				dur = T_MAX;
				rate = 31'd2;
			end else if (roll == 0) begin
				dur = 31'($urandom_range(1, 32'(T_MAX)));
				ratio = (64'sd1 <<< 32) / longint'(dur);
				rate = (ratio > T_MAX) ? T_MAX : 31'(ratio);
			end else begin
				dur = 31'($urandom_range(16384, 1 << 20));
				rate = 31'((64'sd1 <<< 32) / longint'(dur));
				if (roll == 1)
					rate = 31'($urandom_range(1, 32'(T_MAX)));
			end
			write_reg(REG_DURATION, dur);
			write_reg(REG_INV_DURATION, rate);
			steady_sender = (phase % 3 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 3 && n == PHASE_ITEMS / 2)
					settle(0);
				send_request(next_item());
			end
			settle(IDLE_GAP);
		end

		if (predictor.errors == 0 && predictor.pending_torques.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
